/* src/tcw_pkg.sv */
// Package for the text console writer: command and result structs, operation,
// control character and register index codes, controller states.
// No dependencies; imported by tcw_ram users and the top level.
`default_nettype none

package tcw_pkg;

    // Operation codes carried by a command.
    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // One command as it arrives on the input side.
    typedef struct packed {
        op_t         op;
        logic [7:0]  char_code;
        logic [10:0] cell_address;
    } command_t;

    // One result as it leaves on the output side.
    typedef struct packed {
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_position;
        logic [15:0] cell_value;
        logic        scrolled;
    } result_t;

    // Control characters and the blank.
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_BLANK = 8'h20;

    // Configuration register indexes and reset values.
    localparam int         CFG_INDEX_W    = 2;
    localparam logic [1:0] CFG_TEXT_ATTR  = 2'd0;
    localparam logic [1:0] CFG_CLEAR_ATTR = 2'd1;
    localparam logic [1:0] CFG_PROT_COLS  = 2'd2;

    localparam logic [7:0] RESET_TEXT_ATTR  = 8'd15;
    localparam logic [7:0] RESET_CLEAR_ATTR = 8'd7;
    localparam logic [6:0] RESET_PROT_COLS  = 7'd10;

    // Controller states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_SCROLL_TAIL,
        ST_CLEAR,
        ST_REPORT
    } state_t;

endpackage

`default_nettype wire

/* src/tcw_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write first in program order; a read of the address being written
    // returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/text_console_writer.sv */
// Text console writer top level: cursor control, screen memory sequencing,
// configuration registers and result register.
// Depends on tcw_pkg and tcw_ram.
//
//  Channel   Signals                               Transfer
//  -------   -----------------------------------   ---------------------------------
//  command   start, busy, command                   edge with start high and busy low
//  result    done, result                          every edge that ends a done cycle
//  config    cfg_valid, cfg_ready, cfg_index,      edge with cfg_valid and cfg_ready
//            cfg_data
//
// A put without scroll, a read and the no-op go through the execute and report
// states before the done strobe; the next command can be taken in the cycle the
// strobe shows. A scroll adds the scroll and scroll-tail states and a clear adds
// the clear state, both set by the single write port of the screen memory, one
// cell a cycle. After reset, busy stays high while the memory is filled with
// blanks; configuration writes are taken throughout.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire command_t               command,
    output logic                        done,
    output result_t                     result,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int MOVE      = (ROWS - 1) * COLUMNS;
    localparam int AW        = $clog2(CELLS);
    localparam int COL_W     = $clog2(COLUMNS + TAB_WIDTH);
    localparam int COL_IDX_W = $clog2(COLUMNS);
    localparam int ROW_W     = $clog2(ROWS + 1);
    localparam int WRAP_W    = $clog2(ROWS + 1);
    localparam int POS_W     = $clog2(ROWS * COLUMNS + COLUMNS + TAB_WIDTH);

    state_t            state_reg, state_next;
    command_t          cmd_reg;
    logic [COL_W-1:0]  column_reg, column_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [WRAP_W-1:0] wrap_reg, wrap_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic              scrolled_reg, scrolled_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;
    logic [7:0]        text_attr_reg;
    logic [7:0]        clear_attr_reg;
    logic [6:0]        prot_cols_reg;

    // Screen memory ports.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    // Put-character datapath.
    logic [COL_W-1:0]  col1, col2, col3, wr_col;
    logic [ROW_W-1:0]  row1, row2, row3, wr_row;
    logic [WRAP_W-1:0] wrap1, wrap2;
    logic [7:0]        wr_char;
    logic              cell_we;
    logic              scroll_now;
    logic [POS_W-1:0]  wr_pos;
    logic              wr_in_range;
    logic              rd_hit;
    logic              is_put;
    logic              sweep_last_cell;
    logic              sweep_last_move;
    logic [POS_W-1:0]  cursor_pos;

    logic [COL_W-1:0] tab_stop [COLUMNS];

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next tab stop for every column, worked out at elaboration.
    for (genvar gc = 0; gc < COLUMNS; gc++)
    begin : g_tab
        localparam int Stop = (gc / TAB_WIDTH + 1) * TAB_WIDTH;
        assign tab_stop[gc] = COL_W'(Stop);
    end

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    assign is_put          = (cmd_reg.op == OP_PUT);
    assign rd_hit          = (32'(cmd_reg.cell_address) < 32'(CELLS));
    assign sweep_last_cell = (sweep_reg == AW'(CELLS - 1));
    assign sweep_last_move = (sweep_reg == AW'(MOVE - 1));

    // Cursor update for one character: the character itself, then the wrap,
    // then the scroll check.
    always_comb
    begin
        col1    = column_reg;
        row1    = row_reg;
        wrap1   = wrap_reg;
        wr_col  = column_reg;
        wr_row  = row_reg;
        wr_char = cmd_reg.char_code;
        cell_we = 1'b0;
        case (cmd_reg.char_code)
            CHAR_BS:
            begin
                wr_char = CHAR_BLANK;
                if (wrap_reg == '0)
                begin
                    // Refused at or left of the protected columns.
                    if (8'(column_reg) > {1'b0, prot_cols_reg})
                    begin
                        col1    = column_reg - 1'b1;
                        cell_we = 1'b1;
                    end
                end
                else if (column_reg == '0)
                begin
                    // Step back across a wrap to the end of the previous row.
                    col1    = COL_W'(COLUMNS - 1);
                    row1    = (row_reg != '0) ? row_reg - 1'b1 : row_reg;
                    wrap1   = wrap_reg - 1'b1;
                    cell_we = 1'b1;
                end
                else
                begin
                    col1    = column_reg - 1'b1;
                    cell_we = 1'b1;
                end
                wr_col = col1;
                wr_row = row1;
            end
            CHAR_TAB:
            begin
                col1 = tab_stop[column_reg[COL_IDX_W-1:0]];
            end
            CHAR_CR:
            begin
                col1 = '0;
            end
            CHAR_LF:
            begin
                wrap1 = '0;
                col1  = '0;
                if (row_reg < ROW_W'(ROWS))
                begin
                    row1 = row_reg + 1'b1;
                end
            end
            default:
            begin
                if (cmd_reg.char_code >= CHAR_BLANK)
                begin
                    cell_we = 1'b1;
                    col1    = column_reg + 1'b1;
                end
            end
        endcase

        // Wrap past the last column.
        col2  = col1;
        row2  = row1;
        wrap2 = wrap1;
        if (col1 >= COL_W'(COLUMNS))
        begin
            col2 = '0;
            if (wrap1 < WRAP_W'(ROWS))
            begin
                wrap2 = wrap1 + 1'b1;
            end
            if (row1 < ROW_W'(ROWS))
            begin
                row2 = row1 + 1'b1;
            end
        end

        // Reaching the last row scrolls the screen up one row.
        scroll_now = (row2 >= ROW_W'(ROWS - 1));
        col3       = col2;
        row3       = row2;
        if (scroll_now)
        begin
            col3 = '0;
            row3 = row2 - 1'b1;
        end
    end

    assign wr_pos      = POS_W'(wr_row) * POS_W'(COLUMNS) + POS_W'(wr_col);
    assign wr_in_range = (wr_pos < POS_W'(CELLS));
    assign cursor_pos  = POS_W'(row_reg) * POS_W'(COLUMNS) + POS_W'(column_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (sweep_last_cell)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (cmd_reg.op)
                    OP_PUT:   state_next = scroll_now ? ST_SCROLL : ST_REPORT;
                    OP_CLEAR: state_next = ST_CLEAR;
                    default:  state_next = ST_REPORT;
                endcase
            end
            ST_SCROLL:
            begin
                if (sweep_last_move)
                begin
                    state_next = ST_SCROLL_TAIL;
                end
            end
            ST_SCROLL_TAIL:
            begin
                state_next = ST_REPORT;
            end
            ST_CLEAR:
            begin
                if (sweep_last_cell)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Screen memory controls for each state. During a scroll the cell one row
    // below is read while the cell read in the previous cycle is written back
    // one row up.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = sweep_reg;
        ram_wdata = {clear_attr_reg, CHAR_BLANK};
        ram_re    = 1'b0;
        ram_raddr = AW'(sweep_reg + AW'(COLUMNS));
        unique case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = {RESET_CLEAR_ATTR, CHAR_BLANK};
            end
            ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            ST_EXEC:
            begin
                ram_we    = is_put && cell_we && wr_in_range;
                ram_waddr = AW'(wr_pos);
                ram_wdata = {text_attr_reg, wr_char};
                ram_re    = (cmd_reg.op == OP_READ) && rd_hit;
                ram_raddr = AW'(cmd_reg.cell_address);
            end
            ST_SCROLL:
            begin
                ram_re    = 1'b1;
                ram_we    = (sweep_reg != '0);
                ram_waddr = sweep_reg - 1'b1;
                ram_wdata = ram_rdata;
            end
            ST_SCROLL_TAIL:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            ST_IDLE, ST_REPORT:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Next values of the cursor, sweep counter and result.
    always_comb
    begin
        column_next   = column_reg;
        row_next      = row_reg;
        wrap_next     = wrap_reg;
        sweep_next    = sweep_reg;
        scrolled_next = scrolled_reg;
        done_next     = (state_reg == ST_REPORT);
        result_next   = result_reg;

        if (state_reg == ST_EXEC)
        begin
            sweep_next    = '0;
            scrolled_next = is_put && scroll_now;
            if (is_put)
            begin
                column_next = col3;
                row_next    = row3;
                wrap_next   = wrap2;
            end
            else if (cmd_reg.op == OP_CLEAR)
            begin
                column_next = '0;
                row_next    = '0;
            end
        end

        if (((state_reg == ST_INIT) || (state_reg == ST_CLEAR)) && !sweep_last_cell)
        begin
            sweep_next = sweep_reg + 1'b1;
        end
        if ((state_reg == ST_SCROLL) && !sweep_last_move)
        begin
            sweep_next = sweep_reg + 1'b1;
        end

        if (state_reg == ST_REPORT)
        begin
            result_next.cursor_column   = 7'(column_reg);
            result_next.cursor_row      = 5'(row_reg);
            result_next.cursor_position = 11'(cursor_pos);
            result_next.cell_value      = ((cmd_reg.op == OP_READ) && rd_hit) ?
                                          ram_rdata : 16'h0000;
            result_next.scrolled        = scrolled_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            column_reg   <= '0;
            row_reg      <= '0;
            wrap_reg     <= '0;
            sweep_reg    <= '0;
            scrolled_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            column_reg   <= column_next;
            row_reg      <= row_next;
            wrap_reg     <= wrap_next;
            sweep_reg    <= sweep_next;
            scrolled_reg <= scrolled_next;
            done_reg     <= done_next;
        end
    end

    // Command and result payload.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= command;
        end
        result_reg <= result_next;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attr_reg  <= RESET_TEXT_ATTR;
            clear_attr_reg <= RESET_CLEAR_ATTR;
            prot_cols_reg  <= RESET_PROT_COLS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TEXT_ATTR:  text_attr_reg  <= cfg_data;
                CFG_CLEAR_ATTR: clear_attr_reg <= cfg_data;
                CFG_PROT_COLS:  prot_cols_reg  <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    // A strobe only ever follows the report state.
    a_done_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_REPORT))
        else $error("result strobe without a report cycle");

    // Between commands the cursor lies on the screen above the last row.
    a_cursor_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |->
            ((row_reg <= ROW_W'(ROWS - 2)) && (column_reg < COL_W'(COLUMNS))))
        else $error("cursor outside the screen while idle");

    // A read reports through the execute and report states after its transfer.
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command.op == OP_READ)) |=> ##2 done)
        else $error("read result late");

    // The wrap count saturates at the row count.
    a_wrap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wrap_reg <= WRAP_W'(ROWS))
        else $error("wrap count past its limit");

endmodule

`default_nettype wire
